### rtl/tscb_pkg.sv
// ----------------------------------------------------------------------------
// tscb_pkg
// Shared types and constants of the table driven byte stream cipher.
// ----------------------------------------------------------------------------
package tscb_pkg;

  localparam int TableDepth    = 256;
  localparam int KeyBytesDef   = 32;
  localparam int NonceBytesDef = 8;

  localparam logic [7:0] LastEntry  = 8'(TableDepth - 1);
  localparam logic [7:0] HalfOffset = 8'(TableDepth / 2);

  // Configuration register indexes.
  localparam logic [2:0] CfgKey0  = 3'd0;
  localparam logic [2:0] CfgKey3  = 3'd3;
  localparam logic [2:0] CfgNonce = 3'd4;

  // Input operation codes.
  localparam logic OpRekey = 1'b0;
  localparam logic OpData  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_K_RD,
    ST_K_WR,
    ST_S_RD_A,
    ST_S_RD_B,
    ST_S_WR,
    ST_N_RD,
    ST_N_WR,
    ST_F_RD_A,
    ST_F_RD_B,
    ST_F_WR,
    ST_F_RD_J,
    ST_F_UPD,
    ST_X_RD_A,
    ST_X_RD_B,
    ST_X_RD_C,
    ST_X_WR,
    ST_D_RD_J,
    ST_D_RD_BC,
    ST_D_RD_TJ,
    ST_D_WR,
    ST_D_RD_K,
    ST_D_OUT
  } state_e;

endpackage

### rtl/table_stream_cipher_byte.sv
// ----------------------------------------------------------------------------
// table_stream_cipher_byte
// Byte stream cipher over a 256-entry state table with a walk index.
//
// Usage: the input channel (in_valid_i/in_ready_o) carries op_i and
// data_in_i. op_i = 0 rekeys from the key and nonce registers, op_i = 1
// encrypts or decrypts data_in_i. Each item yields one result on the output
// channel (out_valid_o/out_ready_i) with data_out_o and rekey_done_o.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must do so only while idle, as the block itself does not enforce it.
// All table traffic goes through one write port and one read port with a
// registered read, and every step waits for the read it depends on. One
// item is in work at a time; in_ready_o is high only while the sequencer
// is idle. The result sits in an output register, so a new item is taken
// while it waits. If the receiver stalls, the sequencer holds in its last
// step until the output register is free. Reset clears the table (through
// per-entry valid bits), the indices, the key and nonce registers and the
// output valid flag; data before any rekey runs on the all-zero table.
// ----------------------------------------------------------------------------
module table_stream_cipher_byte #(
  parameter int KEY_BYTES   = tscb_pkg::KeyBytesDef,
  parameter int NONCE_BYTES = tscb_pkg::NonceBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  data_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  data_out_o,
  output logic        rekey_done_o
);
  import tscb_pkg::*;

  localparam int MW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [MW-1:0] LastM = MW'(KEY_BYTES - 1);
  localparam logic [7:0] LastKey    = 8'(KEY_BYTES - 1);
  localparam logic [7:0] LastNonce  = 8'(NONCE_BYTES - 1);
  localparam logic [7:0] LastSpread = 8'(TableDepth - KEY_BYTES - 1);
  localparam logic [7:0] KeyOffset  = 8'(KEY_BYTES);

  state_e state_q, state_d;

  logic [3:0][63:0] key_q;
  logic [63:0]      nonce_q;

  logic [7:0]    c_q, c_d;
  logic [MW-1:0] m_q, m_d;
  logic [7:0]    j_q, j_d;
  logic [7:0]    a_q, a_d;
  logic [7:0]    b_q, b_d;
  logic [7:0]    bc_q, bc_d;
  logic          second_q, second_d;
  logic [7:0]    din_q;

  logic       out_valid_q;
  logic [7:0] out_data_q, out_data_d;
  logic       out_done_q, out_done_d;
  logic       load;
  logic       out_free;

  // Table memory with valid bits; an entry that is not valid reads as zero.
  logic [7:0]            mem [TableDepth];
  logic [TableDepth-1:0] vld_q;
  logic [7:0]            rdata_q;
  logic                  rvld_q;
  logic [7:0]            rd;
  logic                  mem_we;
  logic [7:0]            mem_waddr;
  logic [7:0]            mem_raddr;
  logic                  clear_vld;

  // Shared adder: every value written to the table goes through it.
  logic [7:0] alu_a, alu_b, alu_c, alu_y;

  logic [7:0] key_byte;
  logic [7:0] nonce_byte;
  logic       in_fire;

  assign rd         = rvld_q ? rdata_q : 8'd0;
  assign alu_y      = alu_a + alu_b + alu_c;
  assign key_byte   = key_q[c_q[4:3]][{c_q[2:0], 3'b000} +: 8];
  assign nonce_byte = nonce_q[{c_q[2:0], 3'b000} +: 8];
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= alu_y;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[mem_raddr];
      if (clear_vld) begin
        vld_q <= '0;
      end else if (mem_we) begin
        vld_q[mem_waddr] <= 1'b1;
      end
    end
  end

  // Key words sit at the lowest indexes, starting at zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      nonce_q <= '0;
    end else if (cfg_we_i) begin
      priority if (cfg_idx_i <= CfgKey3) begin
        key_q[cfg_idx_i[1:0]] <= cfg_data_i;
      end else if (cfg_idx_i == CfgNonce) begin
        nonce_q <= cfg_data_i;
      end else begin
        nonce_q <= nonce_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      c_q         <= '0;
      m_q         <= '0;
      j_q         <= '0;
      bc_q        <= '0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      c_q      <= c_d;
      m_q      <= m_d;
      j_q      <= j_d;
      bc_q     <= bc_d;
      second_q <= second_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    if (in_fire) begin
      din_q <= data_in_i;
    end
    if (load) begin
      out_data_q <= out_data_d;
      out_done_q <= out_done_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    c_d        = c_q;
    m_d        = m_q;
    j_d        = j_q;
    a_d        = a_q;
    b_d        = b_q;
    bc_d       = bc_q;
    second_d   = second_q;
    in_ready_o = 1'b0;
    clear_vld  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = c_q;
    mem_raddr  = c_q;
    alu_a      = rd;
    alu_b      = 8'd0;
    alu_c      = 8'd0;
    load       = 1'b0;
    out_data_d = 8'd0;
    out_done_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (op_i == OpRekey) begin
            c_d       = '0;
            m_d       = '0;
            j_d       = '0;
            bc_d      = '0;
            second_d  = 1'b0;
            clear_vld = 1'b1;
            state_d   = ST_K_RD;
          end else begin
            state_d = ST_D_RD_J;
          end
        end
      end

      // Key pass: t[c] += key[c]; j += t[c] + c.
      ST_K_RD: state_d = ST_K_WR;
      ST_K_WR: begin
        alu_b  = key_byte;
        mem_we = 1'b1;
        j_d    = j_q + alu_y + c_q;
        if (c_q == LastKey) begin
          c_d     = '0;
          m_d     = '0;
          state_d = ST_S_RD_A;
        end else begin
          c_d     = c_q + 8'd1;
          state_d = ST_K_RD;
        end
      end

      // Scatter pass: t[j] += t[c mod L]; j = t[j].
      ST_S_RD_A: begin
        mem_raddr = 8'(m_q);
        state_d   = ST_S_RD_B;
      end
      ST_S_RD_B: begin
        a_d       = rd;
        mem_raddr = j_q;
        state_d   = ST_S_WR;
      end
      ST_S_WR: begin
        alu_b     = a_q;
        mem_we    = 1'b1;
        mem_waddr = j_q;
        j_d       = alu_y;
        m_d       = (m_q == LastM) ? '0 : m_q + MW'(1);
        c_d       = c_q + 8'd1;
        if (c_q == LastEntry) begin
          state_d = second_q ? ST_F_RD_A : ST_N_RD;
        end else begin
          state_d = ST_S_RD_A;
        end
      end

      // Nonce pass: t[c] += nonce[c]; j += t[c].
      ST_N_RD: state_d = ST_N_WR;
      ST_N_WR: begin
        alu_b  = nonce_byte;
        mem_we = 1'b1;
        j_d    = j_q + alu_y;
        if (c_q == LastNonce) begin
          c_d      = '0;
          m_d      = '0;
          second_d = 1'b1;
          state_d  = ST_S_RD_A;
        end else begin
          c_d     = c_q + 8'd1;
          state_d = ST_N_RD;
        end
      end

      // Spread pass: t[c+L] = t[c] + t[(c+1) mod (256-L)] + j; j = t[j] + t[c].
      ST_F_RD_A: state_d = ST_F_RD_B;
      ST_F_RD_B: begin
        a_d       = rd;
        mem_raddr = (c_q == LastSpread) ? 8'd0 : c_q + 8'd1;
        state_d   = ST_F_WR;
      end
      ST_F_WR: begin
        alu_b     = a_q;
        alu_c     = j_q;
        mem_we    = 1'b1;
        mem_waddr = c_q + KeyOffset;
        state_d   = ST_F_RD_J;
      end
      ST_F_RD_J: begin
        mem_raddr = j_q;
        state_d   = ST_F_UPD;
      end
      ST_F_UPD: begin
        alu_b = a_q;
        j_d   = alu_y;
        if (c_q == LastSpread) begin
          c_d     = '0;
          state_d = ST_X_RD_A;
        end else begin
          c_d     = c_q + 8'd1;
          state_d = ST_F_RD_A;
        end
      end

      // Mix pass: t[c] += t[c+128] + t[j]; j += new t[c].
      ST_X_RD_A: state_d = ST_X_RD_B;
      ST_X_RD_B: begin
        a_d       = rd;
        mem_raddr = c_q + HalfOffset;
        state_d   = ST_X_RD_C;
      end
      ST_X_RD_C: begin
        alu_b     = a_q;
        a_d       = alu_y;
        mem_raddr = j_q;
        state_d   = ST_X_WR;
      end
      ST_X_WR: begin
        mem_raddr = j_q;
        alu_b     = a_q;
        // The last write waits for a free output register, so it is done once.
        if (c_q != LastEntry || out_free) begin
          mem_we = 1'b1;
          j_d    = j_q + alu_y;
          c_d    = c_q + 8'd1;
          if (c_q == LastEntry) begin
            load       = 1'b1;
            out_done_d = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_X_RD_A;
          end
        end
      end

      // Data: j = t[j]; t[j] = t[bc] - t[j]; ks = t[t[j]] + t[j].
      ST_D_RD_J: begin
        mem_raddr = j_q;
        state_d   = ST_D_RD_BC;
      end
      ST_D_RD_BC: begin
        j_d       = rd;
        mem_raddr = bc_q;
        state_d   = ST_D_RD_TJ;
      end
      ST_D_RD_TJ: begin
        a_d       = rd;
        mem_raddr = j_q;
        state_d   = ST_D_WR;
      end
      ST_D_WR: begin
        alu_a     = a_q;
        alu_b     = ~rd;
        alu_c     = 8'd1;
        mem_we    = 1'b1;
        mem_waddr = j_q;
        b_d       = alu_y;
        state_d   = ST_D_RD_K;
      end
      ST_D_RD_K: begin
        mem_raddr = b_q;
        state_d   = ST_D_OUT;
      end
      ST_D_OUT: begin
        mem_raddr = b_q;
        alu_b     = b_q;
        if (out_free) begin
          load       = 1'b1;
          out_data_d = din_q ^ alu_y;
          bc_d       = bc_q + 8'd1;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = out_data_q;
  assign rekey_done_o = out_done_q;

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("result register not valid after load");

  a_rekey_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rekey_done_o) |-> (data_out_o == 8'd0))
    else $error("rekey result carries nonzero data");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("table written while idle");

  a_accept_no_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !load)
    else $error("input transfer while a result is loaded");

endmodule
